### hw/rtl/icmp_er_pkg.sv
// Shared types and constants for the ICMP echo responder.
// No dependencies; imported by the output channel interface, the top level and the testbench.
package icmp_er_pkg;

    // Message framing limits
    localparam int MAX_MESSAGE = 1500;
    localparam int COUNT_W     = 14;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] HDR_LEN   = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] MSG_LIMIT = COUNT_W'(MAX_MESSAGE);

    // ICMP type codes
    localparam logic [7:0] TYPE_REQUEST = 8'd8;
    localparam logic [7:0] TYPE_REPLY   = 8'd0;

    // Header offsets that get special handling
    localparam logic [COUNT_W-1:0] OFF_TYPE   = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] OFF_CSUM_H = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] OFF_CSUM_L = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] OFF_IDENT_H = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] OFF_IDENT_L = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] OFF_SEQ_H  = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] OFF_SEQ_L  = COUNT_W'(7);

    // Reset value of the ping identifier register
    localparam logic [15:0] IDENT_RESET = 16'h5245;

    // Verdict codes
    typedef enum logic [1:0] {
        VERDICT_IGNORE = 2'd0,
        VERDICT_REPLY  = 2'd1,
        VERDICT_SEEN   = 2'd2
    } verdict_t;

    // One result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        verdict_t    verdict;
        logic [15:0] reply_checksum;
        logic [31:0] reply_dest;
        logic [15:0] seen_sequence;
    } result_t;

endpackage

### hw/rtl/icmp_er_in_if.sv
// Input channel of the ICMP echo responder: one message byte per item.
// Depends on nothing beyond plain logic types.
interface icmp_er_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  in_byte;
    logic        in_last;
    logic [31:0] src_addr;

    modport source (output valid, output in_byte, output in_last, output src_addr,
                    input ready);
    modport sink   (input valid, input in_byte, input in_last, input src_addr,
                    output ready);
endinterface

### hw/rtl/icmp_er_out_if.sv
// Output channel of the ICMP echo responder: one rewritten byte plus verdict per item.
// Depends on icmp_er_pkg for the verdict type.
interface icmp_er_out_if
    import icmp_er_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_last;
    verdict_t    verdict;
    logic [15:0] reply_checksum;
    logic [31:0] reply_dest;
    logic [15:0] seen_sequence;

    modport source (output valid, output out_byte, output out_last, output verdict,
                    output reply_checksum, output reply_dest, output seen_sequence,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input verdict,
                    input reply_checksum, input reply_dest, input seen_sequence,
                    output ready);
endinterface

### hw/rtl/icmp_echo_responder.sv
// ICMP echo responder top level: header rewrite, checksum and verdict.
// Depends on icmp_er_pkg, icmp_er_in_if and icmp_er_out_if.
//
// Usage:
//   in_ch carries an ICMP message one byte per item, header first, with
//   in_last on the final byte and the sender address sampled with it.
//   out_ch returns one item per input item: the byte with type 8 made 0 and
//   the checksum bytes zeroed. On the last byte the verdict fields are set:
//   send an echo reply (checksum and destination given) or a matching echo
//   reply seen (sequence given); otherwise they are zero.
//   cfg_we/cfg_wdata write the ping identifier; write it only while idle.
// Timing:
//   One item per clock sustained while out_ch takes them. Each result is
//   registered in the output register, or in the skid register when out_ch
//   stalls. All per-byte work (one 16-bit end-around add plus a few compares)
//   fits between the message state registers and the output register.
// Reset:
//   rst_n clears the message state and the valid flags of both output stages; the ping
//   identifier returns to 0x5245.
// Stall:
//   A skid register behind the output register keeps in_ch ready for one
//   more item when out_ch stalls; ready drops only once the skid is full.
module icmp_echo_responder
    import icmp_er_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    icmp_er_in_if.sink          in_ch,
    icmp_er_out_if.source       out_ch,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);

    // Configuration and message state
    logic [15:0]        ping_ident_reg;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]        sum_accum_reg, sum_accum_next;
    logic [7:0]         high_byte_hold_reg, high_byte_hold_next;
    logic [7:0]         msg_type_reg, msg_type_next;
    logic [15:0]        msg_ident_reg, msg_ident_next;
    logic [15:0]        msg_sequence_reg, msg_sequence_next;

    // Output stages
    result_t out_data_reg, skid_data_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic    accept;
    logic    out_take;
    result_t res_now;

    // Per-byte datapath
    logic [7:0]         ob;
    logic [COUNT_W-1:0] off;
    logic [COUNT_W-1:0] len;
    logic [15:0]        addend;
    logic [16:0]        raw_sum;
    logic [15:0]        sum_new;
    logic               len_ok;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_take = out_valid_reg && out_ch.ready;
    assign in_ch.ready = !skid_valid_reg;

    always_comb
    begin
        off = byte_count_reg;
        ob  = in_ch.in_byte;
        msg_type_next     = msg_type_reg;
        msg_ident_next    = msg_ident_reg;
        msg_sequence_next = msg_sequence_reg;

        // header field capture and rewrite
        if (off == OFF_TYPE)
        begin
            msg_type_next = in_ch.in_byte;
            if (in_ch.in_byte == TYPE_REQUEST)
                ob = 8'd0;
        end
        else if (off == OFF_CSUM_H || off == OFF_CSUM_L)
            ob = 8'd0;
        else if (off == OFF_IDENT_H)
            msg_ident_next = {in_ch.in_byte, msg_ident_reg[7:0]};
        else if (off == OFF_IDENT_L)
            msg_ident_next = {msg_ident_reg[15:8], in_ch.in_byte};
        else if (off == OFF_SEQ_H)
            msg_sequence_next = {in_ch.in_byte, msg_sequence_reg[7:0]};
        else if (off == OFF_SEQ_L)
            msg_sequence_next = {msg_sequence_reg[15:8], in_ch.in_byte};

        // ones' complement word sum; odd final byte padded with zero
        high_byte_hold_next = high_byte_hold_reg;
        if (!off[0])
        begin
            high_byte_hold_next = ob;
            addend = in_ch.in_last ? {ob, 8'd0} : 16'd0;
        end
        else
            addend = {high_byte_hold_reg, ob};
        raw_sum = {1'b0, sum_accum_reg} + {1'b0, addend};
        sum_new = raw_sum[15:0] + {15'd0, raw_sum[16]};
        sum_accum_next = sum_new;

        // saturating length
        len = (off < COUNT_MAX) ? off + COUNT_W'(1) : COUNT_MAX;
        byte_count_next = len;
        len_ok = (len >= HDR_LEN) && (len <= MSG_LIMIT);

        // result item
        res_now.out_byte       = ob;
        res_now.out_last       = in_ch.in_last;
        res_now.verdict        = VERDICT_IGNORE;
        res_now.reply_checksum = 16'd0;
        res_now.reply_dest     = 32'd0;
        res_now.seen_sequence  = 16'd0;
        if (in_ch.in_last)
        begin
            if (len_ok && msg_type_next == TYPE_REQUEST)
            begin
                res_now.verdict        = VERDICT_REPLY;
                res_now.reply_checksum = ~sum_new;
                res_now.reply_dest     = in_ch.src_addr;
            end
            else if (len_ok && msg_type_next == TYPE_REPLY
                     && msg_ident_next == ping_ident_reg)
            begin
                res_now.verdict       = VERDICT_SEEN;
                res_now.seen_sequence = msg_sequence_next;
            end
            // message done: start fresh
            byte_count_next     = '0;
            sum_accum_next      = '0;
            high_byte_hold_next = '0;
            msg_type_next       = '0;
            msg_ident_next      = '0;
            msg_sequence_next   = '0;
        end
    end

    // Ping identifier register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ping_ident_reg <= IDENT_RESET;
        else if (cfg_we)
            ping_ident_reg <= cfg_wdata;
    end

    // Message state, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg     <= '0;
            sum_accum_reg      <= '0;
            high_byte_hold_reg <= '0;
            msg_type_reg       <= '0;
            msg_ident_reg      <= '0;
            msg_sequence_reg   <= '0;
        end
        else if (accept)
        begin
            byte_count_reg     <= byte_count_next;
            sum_accum_reg      <= sum_accum_next;
            high_byte_hold_reg <= high_byte_hold_next;
            msg_type_reg       <= msg_type_next;
            msg_ident_reg      <= msg_ident_next;
            msg_sequence_reg   <= msg_sequence_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= accept;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= res_now;
        end
        else if (accept)
            skid_data_reg <= res_now;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.out_byte       = out_data_reg.out_byte;
    assign out_ch.out_last       = out_data_reg.out_last;
    assign out_ch.verdict        = out_data_reg.verdict;
    assign out_ch.reply_checksum = out_data_reg.reply_checksum;
    assign out_ch.reply_dest     = out_data_reg.reply_dest;
    assign out_ch.seen_sequence  = out_data_reg.seen_sequence;

endmodule

### tb/icmp_er_checker.sv
`timescale 1ns / 1ps
// Checker for the ICMP echo responder: tracks the rewrite, checksum and verdict per byte.
// Depends on icmp_er_pkg, icmp_er_in_if and icmp_er_out_if; watches only, drives nothing on the channels.
module icmp_er_checker
    import icmp_er_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    icmp_er_in_if        in_ch,
    icmp_er_out_if       out_ch,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    output int           errors,
    output int           pending
);

    // Own copy of the message state and the identifier register
    logic [COUNT_W-1:0] byte_cnt;
    logic [15:0]        word_sum;
    logic [7:0]         hi_byte;
    logic [7:0]         type_seen;
    logic [15:0]        ident_seen;
    logic [15:0]        seq_seen;
    logic [15:0]        ping_id;

    result_t            rewritten_due[$];
    result_t            head;
    int                 mismatch_cnt;

    // 16-bit add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    task automatic clear_msg();
        byte_cnt   = '0;
        word_sum   = '0;
        hi_byte    = '0;
        type_seen  = '0;
        ident_seen = '0;
        seq_seen   = '0;
    endtask

    // Rewrite one accepted byte, fold it into the sum, queue the result it causes
    task automatic track_byte(input logic [7:0] b, input logic lst, input logic [31:0] src);
        result_t            r;
        logic [7:0]         ob;
        logic [COUNT_W-1:0] off;
        logic [COUNT_W-1:0] len;
        ob  = b;
        off = byte_cnt;
        if (off == OFF_TYPE)
        begin
            type_seen = b;
            if (b == TYPE_REQUEST)
                ob = 8'h00;
        end
        else if (off == OFF_CSUM_H || off == OFF_CSUM_L)
            ob = 8'h00;
        else if (off == OFF_IDENT_H)
            ident_seen[15:8] = b;
        else if (off == OFF_IDENT_L)
            ident_seen[7:0] = b;
        else if (off == OFF_SEQ_H)
            seq_seen[15:8] = b;
        else if (off == OFF_SEQ_L)
            seq_seen[7:0] = b;

        // even offset opens a word; an odd final byte is padded with zero
        if (!off[0])
        begin
            hi_byte = ob;
            if (lst)
                word_sum = ones_add(word_sum, {ob, 8'h00});
        end
        else
            word_sum = ones_add(word_sum, {hi_byte, ob});

        len      = (off != COUNT_MAX) ? off + COUNT_W'(1) : COUNT_MAX;
        byte_cnt = len;

        r          = '0;
        r.out_byte = ob;
        r.out_last = lst;
        r.verdict  = VERDICT_IGNORE;
        if (lst)
        begin
            if (len >= HDR_LEN && len <= MSG_LIMIT)
            begin
                if (type_seen == TYPE_REQUEST)
                begin
                    r.verdict        = VERDICT_REPLY;
                    r.reply_checksum = ~word_sum;
                    r.reply_dest     = src;
                end
                else if (type_seen == TYPE_REPLY && ident_seen == ping_id)
                begin
                    r.verdict       = VERDICT_SEEN;
                    r.seen_sequence = seq_seen;
                end
            end
            clear_msg();
        end
        rewritten_due.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_msg();
            ping_id = IDENT_RESET;
            rewritten_due.delete();
            mismatch_cnt = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                ping_id = cfg_wdata;

            if (out_ch.valid && out_ch.ready)
            begin
                if (rewritten_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got byte %h last %b",
                             $time, out_ch.out_byte, out_ch.out_last);
                    mismatch_cnt++;
                end
                else
                begin
                    head = rewritten_due.pop_front();
                    check_field("out_byte", head.out_byte, out_ch.out_byte);
                    check_field("out_last", head.out_last, out_ch.out_last);
                    check_field("verdict", head.verdict, out_ch.verdict);
                    check_field("reply_checksum", head.reply_checksum, out_ch.reply_checksum);
                    check_field("reply_dest", head.reply_dest, out_ch.reply_dest);
                    check_field("seen_sequence", head.seen_sequence, out_ch.seen_sequence);
                end
            end

            if (in_ch.valid && in_ch.ready)
                track_byte(in_ch.in_byte, in_ch.in_last, in_ch.src_addr);

            errors  <= mismatch_cnt;
            pending <= rewritten_due.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the ICMP echo responder testbench: clock, reset, message stimulus and verdict.
// Depends on icmp_er_pkg, both channel interfaces, the responder and icmp_er_checker.
module tb_top;
    import icmp_er_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int          gap_pct;
    int          stall_pct;
    int          n_errors;
    int          n_pending;
    logic [15:0] cur_ident;

    // run statistics
    int          n_msgs;
    int          n_bytes;
    int          n_req;
    int          n_rep;
    int          n_other;
    int          n_cfg;
    int          phase_start;

    icmp_er_in_if  in_ch();
    icmp_er_out_if out_ch();

    icmp_echo_responder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    icmp_er_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .errors    (n_errors),
        .pending   (n_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: random back-pressure
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Hard stop
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One item, after an optional random gap; returns at the accepting edge
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic [31:0] src);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.in_last  <= lst;
        in_ch.src_addr <= src;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Whole message; fill < 0 means random payload bytes
    task automatic send_message(input logic [7:0] mtype, input logic [15:0] id, input int len,
                                input int fill, input logic [31:0] src);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (i)
                0:       b = mtype;
                4:       b = id[15:8];
                5:       b = id[7:0];
                default: b = (fill < 0) ? 8'($urandom) : 8'(fill);
            endcase
            send_byte(b, i == len - 1, (i == len - 1) ? src : $urandom);
        end
        n_msgs++;
        n_bytes += len;
        if (mtype == TYPE_REQUEST)
            n_req++;
        else if (mtype == TYPE_REPLY)
            n_rep++;
        else
            n_other++;
    endtask

    task automatic random_message();
        int          r;
        int          len;
        logic [7:0]  t;
        logic [15:0] id;
        r = $urandom_range(0, 99);
        if (r < 45)
            t = TYPE_REQUEST;
        else if (r < 85)
            t = TYPE_REPLY;
        else
            t = 8'($urandom);
        id = ($urandom_range(0, 99) < 70) ? cur_ident : 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10)
            len = $urandom_range(1, 7);
        else if (r < 92)
            len = $urandom_range(8, 48);
        else
            len = $urandom_range(49, 200);
        send_message(t, id, len, -1, $urandom);
    endtask

    // Drain, then write the ping identifier while idle
    task automatic write_ident(input logic [15:0] v);
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_ident = v;
        n_cfg++;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = '0;
        in_ch.in_last  = 1'b0;
        in_ch.src_addr = '0;
        gap_pct        = 0;
        stall_pct      = 0;
        cur_ident      = IDENT_RESET;
        n_msgs = 0; n_bytes = 0; n_req = 0; n_rep = 0; n_other = 0; n_cfg = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes and corner messages with the reset identifier
        send_message(TYPE_REQUEST, 16'h0000, 8, 8'h00, 32'h0000_0000);
        send_message(TYPE_REQUEST, 16'hFFFF, 9, 8'hFF, 32'hFFFF_FFFF);   // odd length
        send_message(TYPE_REPLY, IDENT_RESET, 8, -1, $urandom);            // our reply
        send_message(TYPE_REPLY, 16'h1234, 10, -1, $urandom);              // foreign reply
        send_message(8'hFF, IDENT_RESET, 12, 8'hFF, $urandom);             // other type
        send_message(TYPE_REQUEST, 16'h0001, 7, -1, $urandom);             // short
        send_message(TYPE_REQUEST, 16'h0000, 1, -1, $urandom);             // single byte
        send_message(TYPE_REQUEST, 16'h7E7E, 20, -1, $urandom);

        // Random phases, each under a new identifier and idle pattern
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: write_ident(16'h0000);
                1: write_ident(16'hFFFF);
                default: write_ident(16'($urandom));
            endcase
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 77; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 77; end
                default: begin gap_pct = 27; stall_pct = 27; end
            endcase
            phase_start = n_bytes;
            while (n_bytes - phase_start < 450)
                random_message();
        end

        // Drain and settle
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
        repeat (16) @(posedge clk);

        $display("Sent %0d messages, %0d bytes: %0d echo requests, %0d echo replies, %0d other.",
                 n_msgs, n_bytes, n_req, n_rep, n_other);
        $display("Ping identifier written %0d times across four idle patterns.", n_cfg);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
